// ----- sv/pds_pkg.sv -----
// Package: shared constants and types for the pairwise distance sorter.
package pds_pkg;
  localparam int MaxPointsDef = 8;
  localparam int CoordBitsDef = 16;
  localparam int FieldW = 16;
  localparam int DistW = 24;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD, ST_PAIR, ST_DIST, ST_START, ST_SQRT, ST_INS, ST_EMIT
  } state_t;

  // one point per input transfer
  typedef struct packed {
    logic signed [FieldW-1:0] px;
    logic signed [FieldW-1:0] py;
    logic signed [FieldW-1:0] pz;
    logic                     last_point;
  } point_t;

  // one pair per result transfer
  typedef struct packed {
    logic signed [FieldW-1:0] ax;
    logic signed [FieldW-1:0] ay;
    logic signed [FieldW-1:0] az;
    logic signed [FieldW-1:0] bx;
    logic signed [FieldW-1:0] by_coord;
    logic signed [FieldW-1:0] bz;
    logic [DistW-1:0]         dist_centi;
    logic                     overflowed;
    logic                     last_pair;
  } pair_t;

  // shift control handed to each sort cell
  typedef struct packed {
    logic ins;   // insertion in progress this cycle
    logic clr;   // empty the chain
    logic pop;   // head result transferred, shift toward head
  } cell_ctl_t;
endpackage

// ----- sv/pds_if.sv -----
// Interface: valid/ready channel with a generic payload.
interface pds_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/pds_cell.sv -----
// Sort cell: one slot of the descending insertion chain.
module pds_cell #(
  parameter int KW = 34,
  parameter int IW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pds_pkg::cell_ctl_t    ctl,
  input  logic [KW-1:0]         new_key,
  input  logic [IW-1:0]         new_idx,
  input  logic                  prev_valid,
  input  logic                  prev_take,   // an earlier slot moves down
  input  logic [KW-1:0]         prev_key,
  input  logic [IW-1:0]         prev_idx,
  input  logic                  next_valid,
  input  logic [KW-1:0]         next_key,
  input  logic [IW-1:0]         next_idx,
  output logic                  valid_o,
  output logic                  take_o,      // this slot or an earlier one moves down
  output logic [KW-1:0]         key_o,
  output logic [IW-1:0]         idx_o
);
  import pds_pkg::*;
  logic          valid_r;
  logic [KW-1:0] key_r;
  logic [IW-1:0] idx_r;
  logic          shift_here;

  // new key goes before this entry when strictly larger (stable)
  assign shift_here = !valid_r || (new_key > key_r);
  assign take_o     = prev_take || shift_here;
  assign valid_o    = valid_r;
  assign key_o      = key_r;
  assign idx_o      = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.pop) begin
      valid_r <= next_valid;
      key_r   <= next_key;
      idx_r   <= next_idx;
    end else if (ctl.ins && (shift_here || prev_take)) begin
      if (prev_take) begin
        // entry above moves down; an empty one keeps this slot empty
        valid_r <= prev_valid;
        key_r   <= prev_key;
        idx_r   <= prev_idx;
      end else begin
        valid_r <= 1'b1;
        key_r   <= new_key;
        idx_r   <= new_idx;
      end
    end
  end
endmodule

// ----- sv/pds_sqrt.sv -----
// Sequential integer square root with round to nearest, one result bit per cycle.
module pds_sqrt #(
  parameter int VW = 48,
  parameter int RW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VW-1:0] value,
  output logic          done,
  output logic [RW:0]   root
);
  import pds_pkg::*;
  localparam int CW = $clog2(RW + 1);
  logic [VW+1:0] rem_r, rem_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [RW:0]   res_r, res_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [VW+1:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    val_nxt  = val_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      rem_nxt  = '0;
      val_nxt  = value;
      res_nxt  = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // bring down two bits, try res*4+1
      rem_nxt = {rem_r[VW-1:0], val_r[VW-1 -: 2]};
      val_nxt = {val_r[VW-3:0], 2'b00};
      trial   = (VW+2)'({res_r, 2'b01});
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        res_nxt = {res_r[RW-1:0], 1'b1};
      end else begin
        res_nxt = {res_r[RW-1:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // v - r*r > r  ->  round up
        if (rem_nxt > (VW+2)'(res_nxt)) res_nxt = res_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end
  assign done = done_r;
  assign root = res_r;
endmodule

// ----- sv/pairwise_distance_sorter.sv -----
// Flow: points are taken one per cycle while loading; after the point marked last each
// pair goes through setup, the difference/accumulate steps over the three axes, root start,
// a rounded root and a chain insertion.
// Throughput: one batch at a time; once every pair is sorted, results leave one per cycle
// while out_ch.ready holds; no point is accepted until the batch's last result is transferred.
// Reset: synchronous active-low rst_n empties the point count, flag and sort chain.
module pairwise_distance_sorter #(
  parameter int MAX_POINTS = pds_pkg::MaxPointsDef,
  parameter int COORD_BITS = pds_pkg::CoordBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  pds_if.sink   in_ch,
  pds_if.source out_ch
);
  import pds_pkg::*;
  localparam int MaxPairs = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int CNW = $clog2(MAX_POINTS + 1);
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int KW  = SQW + 2;
  localparam int VW0 = KW + 14;
  localparam int VW  = VW0 + (VW0 % 2);
  localparam int RW  = VW / 2;
  localparam int IW  = 2 * PW;
  localparam int CKW = KW + DistW;

  logic [3*COORD_BITS-1:0] store [MAX_POINTS];
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  state_t         st_r, st_nxt;
  logic [PW-1:0]  i_r, i_nxt, k_r, k_nxt;
  logic [1:0]     ax_r, ax_nxt;
  logic [KW-1:0]  d2_r;
  logic [SQW-1:0] sq_r;
  logic [DW-1:0]  df;
  logic [3*COORD_BITS-1:0] pa, pb;
  logic [VW-1:0]  d2w, sq_val;
  logic           sq_start;
  logic           sq_done;
  logic [RW:0]    root;
  logic [DistW-1:0] dc_r;
  cell_ctl_t      ctl;
  logic [CKW-1:0] ins_key;
  logic [IW-1:0]  ins_idx;
  logic [MaxPairs+1:0]      cv;
  logic [MaxPairs:0]        ct;
  logic [CKW-1:0]           ck [MaxPairs+2];
  logic [IW-1:0]            ci [MaxPairs+2];
  logic                     in_fire, out_fire, room;
  logic [COORD_BITS-1:0]    ca, cb;
  logic [PW-1:0]            last_k, last_i;
  logic [PW-1:0]            ea, eb;
  logic [3*COORD_BITS-1:0]  qa, qb;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (st_r == ST_LOAD);
  assign room   = cnt_r < CNW'(MAX_POINTS);
  assign last_k = PW'(cnt_r - CNW'(1));
  assign last_i = PW'(cnt_r - CNW'(2));

  // point capture
  always_ff @(posedge clk) begin
    if (in_fire && room)
      store[cnt_r[PW-1:0]] <= {COORD_BITS'($unsigned(in_ch.data.pz)),
                               COORD_BITS'($unsigned(in_ch.data.py)),
                               COORD_BITS'($unsigned(in_ch.data.px))};
  end

  assign pa = store[i_r];
  assign pb = store[k_r];
  always_comb begin
    case (ax_r)
      2'd0:    begin ca = pa[COORD_BITS-1:0];              cb = pb[COORD_BITS-1:0]; end
      2'd1:    begin
        ca = pa[2*COORD_BITS-1:COORD_BITS];
        cb = pb[2*COORD_BITS-1:COORD_BITS];
      end
      default: begin
        ca = pa[3*COORD_BITS-1:2*COORD_BITS];
        cb = pb[3*COORD_BITS-1:2*COORD_BITS];
      end
    endcase
    df = DW'($signed(ca)) - DW'($signed(cb));
    if (df[DW-1]) df = -df;
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    i_nxt    = i_r;
    k_nxt    = k_r;
    ax_nxt   = ax_r;
    sq_start = 1'b0;
    ctl      = '0;
    case (st_r)
      ST_LOAD: if (in_fire) begin
        if (room) cnt_nxt = cnt_r + 1'b1;
        else ovf_nxt = 1'b1;
        if (in_ch.data.last_point) begin
          i_nxt = '0;
          k_nxt = PW'(1);
          if (cnt_nxt >= CNW'(2)) begin
            st_nxt = ST_PAIR;
          end else begin
            // single point: nothing to emit
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      ST_PAIR: begin
        ax_nxt = '0;
        st_nxt = ST_DIST;
      end
      ST_DIST: begin
        if (ax_r == 2'd3) st_nxt = ST_START;
        else ax_nxt = ax_r + 1'b1;
      end
      ST_START: begin
        sq_start = 1'b1;
        st_nxt   = ST_SQRT;
      end
      ST_SQRT: if (sq_done) st_nxt = ST_INS;
      ST_INS: begin
        ctl.ins = 1'b1;
        st_nxt  = ST_PAIR;
        if (k_r == last_k) begin
          if (i_r == last_i) begin
            st_nxt = ST_EMIT;
          end else begin
            i_nxt = i_r + 1'b1;
            k_nxt = i_r + PW'(2);
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_EMIT: if (out_fire) begin
        ctl.pop = 1'b1;
        if (!cv[2]) begin
          st_nxt  = ST_LOAD;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      i_r   <= '0;
      k_r   <= '0;
      ax_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      i_r   <= i_nxt;
      k_r   <= k_nxt;
      ax_r  <= ax_nxt;
    end
  end

  // squared difference registered, then accumulated
  always_ff @(posedge clk) begin
    if (st_r == ST_PAIR) d2_r <= '0;
    else if (st_r == ST_DIST && ax_r != 2'd0) d2_r <= d2_r + KW'(sq_r);
    sq_r <= SQW'(df) * SQW'(df);
    if (sq_done) dc_r <= (root > (RW+1)'(DistMax)) ? DistMax : DistW'(root);
  end

  // d2 * 10000 as shifted adds (8192 + 1024 + 512 + 256 + 16)
  assign d2w    = VW'(d2_r);
  assign sq_val = (d2w << 13) + (d2w << 10) + (d2w << 9) + (d2w << 8) + (d2w << 4);

  pds_sqrt #(.VW(VW), .RW(RW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(sq_val),
    .done(sq_done), .root(root)
  );

  // key holds d2 above the rounded distance; equal d2 gives equal distance, so order is stable
  assign ins_key = {d2_r, dc_r};
  assign ins_idx = {i_r, k_r};
  assign ct[0] = 1'b0;
  assign cv[0] = 1'b0;
  assign ck[0] = '1;
  assign ci[0] = '0;
  assign cv[MaxPairs+1] = 1'b0;
  assign ck[MaxPairs+1] = '0;
  assign ci[MaxPairs+1] = '0;

  for (genvar g = 0; g < MaxPairs; g++) begin : g_cell
    pds_cell #(.KW(CKW), .IW(IW)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .new_key(ins_key), .new_idx(ins_idx),
      .prev_valid(cv[g]), .prev_take(ct[g]),
      .prev_key(ck[g]), .prev_idx(ci[g]),
      .next_valid(cv[g+2]), .next_key(ck[g+2]), .next_idx(ci[g+2]),
      .valid_o(cv[g+1]), .take_o(ct[g+1]), .key_o(ck[g+1]), .idx_o(ci[g+1])
    );
  end

  // emission: head cell is slot 1
  assign ea = ci[1][IW-1:PW];
  assign eb = ci[1][PW-1:0];
  assign qa = store[ea];
  assign qb = store[eb];

  assign out_ch.valid = (st_r == ST_EMIT) && cv[1];
  always_comb begin
    out_ch.data = '0;
    out_ch.data.ax = FieldW'(qa[COORD_BITS-1:0]);
    out_ch.data.ay = FieldW'(qa[2*COORD_BITS-1:COORD_BITS]);
    out_ch.data.az = FieldW'(qa[3*COORD_BITS-1:2*COORD_BITS]);
    out_ch.data.bx = FieldW'(qb[COORD_BITS-1:0]);
    out_ch.data.by_coord = FieldW'(qb[2*COORD_BITS-1:COORD_BITS]);
    out_ch.data.bz = FieldW'(qb[3*COORD_BITS-1:2*COORD_BITS]);
    out_ch.data.dist_centi = ck[1][DistW-1:0];
    out_ch.data.overflowed = ovf_r;
    out_ch.data.last_pair  = !cv[2];
  end

  property p_load_ready;
    @(posedge clk) disable iff (!rst_n) in_ch.ready |-> !out_ch.valid;
  endproperty
  a_load_ready: assert property (p_load_ready) else $error("ready while emitting");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> cv[1]) else $error("emit from empty chain");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(MAX_POINTS)) else $error("point count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while waiting");
endmodule
